// ===== sv/uudf_pkg.sv =====
// Package with the constants, types and the prime multiply for the dual FNV-1a identifier block.
`default_nettype none

package uudf_pkg;

	localparam int unsigned HashW = 64;
	localparam int unsigned ByteW = 8;

	localparam logic [HashW-1:0] SeedA = 64'hcbf29ce484222325;
	localparam logic [HashW-1:0] SeedB = 64'h84222325cbf29ce4;

	localparam logic [ByteW-1:0] MaskBase = 8'h5a;
	localparam logic [ByteW-1:0] MaskName = 8'ha5;

	localparam logic [HashW-1:0] VerClear = 64'h00f0000000000000;
	localparam logic [HashW-1:0] VerSet   = 64'h0040000000000000;
	localparam logic [HashW-1:0] VarClear = 64'h00000000000000c0;
	localparam logic [HashW-1:0] VarSet   = 64'h0000000000000080;

	typedef struct packed {
		logic en;      // absorb the byte into the accumulator
		logic restart; // return the accumulator to its seed afterwards
	} uudf_lane_ctrl_t;

	// Multiply by the FNV prime 2^40 + 0x1b3, modulo 2^64, as a sum of shifted copies.
	function automatic logic [HashW-1:0] fnv_mul(input logic [HashW-1:0] h);
		fnv_mul = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
	endfunction

endpackage

`default_nettype wire

// ===== sv/uudf_lane.sv =====
// One FNV-1a lane: the accumulator register and its xor-multiply update.
`default_nettype none

module uudf_lane
	import uudf_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [HashW-1:0]      seed,
	input  wire uudf_lane_ctrl_t       ctrl,
	input  wire logic [ByteW-1:0]      data,
	output logic      [HashW-1:0]      hash_next
);

	logic [HashW-1:0] hash_q;

	assign hash_next = fnv_mul(hash_q ^ {{(HashW-ByteW){1'b0}}, data});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= seed;
		end else if (ctrl.en) begin
			if (ctrl.restart) begin
				hash_q <= seed;
			end else begin
				hash_q <= hash_next;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/uuid_derive_dual_fnv1a.sv =====
// Top level of the name-based identifier derivation with two FNV-1a lanes.
// Bytes enter on the slave stream, one word per cycle while s_tready is high: tdata is
// the byte, tuser is set for a base identifier byte and clear for a name byte, tlast
// marks the final byte. Each byte is registered, then absorbed into both 64-bit
// accumulators as it leaves that register, so a byte can be taken every cycle while
// s_tready is high. The word marked last produces one 128-bit result in the output
// register once it advances, and both accumulators return to their seeds. A pending
// result waits in the output register while further non-final bytes keep flowing;
// only a second final byte stalls until the held result is taken.
`default_nettype none

module uuid_derive_dual_fnv1a
	import uudf_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // data_byte[7:0]
	input  wire logic         s_tuser,   // is_base
	input  wire logic         s_tlast,   // last_byte
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [127:0] m_tdata    // first_half[63:0], second_half[127:64]
);

	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             base_s1;
	logic             last_s1;
	logic             advance_s1;
	logic [ByteW-1:0] byte_b;
	logic [HashW-1:0] next_a;
	logic [HashW-1:0] next_b;
	uudf_lane_ctrl_t  lane_ctrl;
	logic             out_valid_q;
	logic [127:0]     out_data_q;

	// A final word may move only when the output register is free or being emptied.
	assign advance_s1 = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			base_s1 <= s_tuser;
			last_s1 <= s_tlast;
		end
	end

	assign byte_b            = byte_s1 ^ (base_s1 ? MaskBase : MaskName);
	assign lane_ctrl.en      = advance_s1;
	assign lane_ctrl.restart = last_s1;

	uudf_lane u_lane_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed      (SeedA),
		.ctrl      (lane_ctrl),
		.data      (byte_s1),
		.hash_next (next_a)
	);

	uudf_lane u_lane_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed      (SeedB),
		.ctrl      (lane_ctrl),
		.data      (byte_b),
		.hash_next (next_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The version nibble and the variant bits are forced as the result is captured.
	always_ff @(posedge clk) begin
		if (advance_s1 && last_s1) begin
			out_data_q <= {(next_b & ~VarClear) | VarSet, (next_a & ~VerClear) | VerSet};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire
